// ===== src/timestamp_aligned_linear_interp_top_defines.svh =====
// Assertion macros for the timestamp aligned linear interpolation block.
// Used by the port checker; needs nothing else.
`ifndef TIMESTAMP_ALIGNED_LINEAR_INTERP_TOP_DEFINES_SVH
`define TIMESTAMP_ALIGNED_LINEAR_INTERP_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define TALI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define TALI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TALI_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/tali_pkg.sv =====
// Shared types, constants and the control program of the interpolation block.
// Used by the top level; depends on nothing.
package tali_pkg;

  localparam int W = 32;
  localparam int Q_FRAC = 16;
  localparam int RATIO_W = Q_FRAC + 1;
  localparam int PROD_W = (W + 1) + (RATIO_W + 1);
  localparam int PC_W = 3;
  localparam int CNT_W = 4;

  localparam logic [1:0] ST_ALIGNED = 2'd0;
  localparam logic [1:0] ST_NO_B = 2'd1;
  localparam logic [1:0] ST_A_SHORT = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  localparam logic [2:0] OP_TAKE = 3'd0;
  localparam logic [2:0] OP_CHECK = 3'd1;
  localparam logic [2:0] OP_DIV_INIT = 3'd2;
  localparam logic [2:0] OP_DIV_STEP = 3'd3;
  localparam logic [2:0] OP_MUL = 3'd4;
  localparam logic [2:0] OP_ADD = 3'd5;
  localparam logic [2:0] OP_EMIT = 3'd6;

  localparam logic [2:0] COND_NEXT = 3'd0;
  localparam logic [2:0] COND_NO_REQ = 3'd1;
  localparam logic [2:0] COND_SKIP = 3'd2;
  localparam logic [2:0] COND_CNT_LEFT = 3'd3;
  localparam logic [2:0] COND_OUT_BUSY = 3'd4;
  localparam logic [2:0] COND_ALWAYS = 3'd5;

  localparam logic [PC_W-1:0] STEP_TAKE = 3'd0;
  localparam logic [PC_W-1:0] STEP_CHECK = 3'd1;
  localparam logic [PC_W-1:0] STEP_DIV_INIT = 3'd2;
  localparam logic [PC_W-1:0] STEP_DIV_STEP = 3'd3;
  localparam logic [PC_W-1:0] STEP_MUL = 3'd4;
  localparam logic [PC_W-1:0] STEP_ADD = 3'd5;
  localparam logic [PC_W-1:0] STEP_EMIT = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] cond;
    logic [PC_W-1:0] target;
  } ctrl_word_t;

  function automatic ctrl_word_t program_rom(input logic [PC_W-1:0] pc);
    ctrl_word_t w;
    unique case (pc)
      STEP_TAKE: w = '{OP_TAKE, COND_NO_REQ, STEP_TAKE};
      STEP_CHECK: w = '{OP_CHECK, COND_SKIP, STEP_EMIT};
      STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEXT, STEP_TAKE};
      STEP_DIV_STEP: w = '{OP_DIV_STEP, COND_CNT_LEFT, STEP_DIV_STEP};
      STEP_MUL: w = '{OP_MUL, COND_NEXT, STEP_TAKE};
      STEP_ADD: w = '{OP_ADD, COND_NEXT, STEP_TAKE};
      STEP_EMIT: w = '{OP_EMIT, COND_OUT_BUSY, STEP_EMIT};
      default: w = '{OP_TAKE, COND_ALWAYS, STEP_TAKE};
    endcase
    return w;
  endfunction

endpackage

// ===== src/timestamp_aligned_linear_interp_top.sv =====
// Timestamp aligned linear interpolation between a slow channel A and a fast
// channel B. Control is a short microprogram; it depends on tali_pkg.
//
// Usage: each slave request carries one cycle-stamped sample, tuser selects
// channel A (0) or channel B (1). The block keeps the two newest A samples
// and the newest B sample and gives exactly one master request per slave
// request: a status in tuser and, when aligned, the A value interpolated at
// B's cycle together with B's value.
// Sequence: a request is taken in the wait step. A failed check or equal A
// cycles go from the check step straight to the emit step; an interpolation
// runs the restoring divider loop (one quotient bit per step, 17-bit
// quotient) and then the multiply and add steps before the emit step. The
// next request can be taken in the cycle after the result is registered;
// the block takes no new request while it works on one.
// The result sits in an output register; the block takes and works on the
// next request while it waits. If the receiver still stalls when the next
// result is ready, the program holds in its emit step until it is taken.
// Reset clears all held samples, the fill count and the output valid; the
// first request after reset reports that no B sample has arrived unless it
// is itself a B sample.
module timestamp_aligned_linear_interp_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] sample_value, [63:32] sample_cycle
  input  logic [0:0]  s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] a_interpolated, [63:32] b_value
  output logic [1:0]  m_tuser    // [1:0] status
);

  localparam int W = tali_pkg::W;

  logic [tali_pkg::PC_W-1:0] pc;
  logic [tali_pkg::PC_W-1:0] pc_next;
  tali_pkg::ctrl_word_t cw;

  logic signed [W-1:0] a_older_value;
  logic signed [W-1:0] a_older_cycle;
  logic signed [W-1:0] a_newer_value;
  logic signed [W-1:0] a_newer_cycle;
  logic [1:0] a_fill;
  logic signed [W-1:0] b_last_value;
  logic signed [W-1:0] b_last_cycle;
  logic b_present;

  logic [1:0] res_status;
  logic signed [W-1:0] res_a;
  logic signed [W-1:0] res_b;

  logic [W-1:0] divisor;
  logic [W-1:0] rem;
  logic [tali_pkg::RATIO_W-1:0] quot;
  logic [tali_pkg::CNT_W-1:0] cnt;
  logic signed [W:0] dv;
  logic signed [tali_pkg::PROD_W-1:0] prod;

  logic in_req;
  logic out_busy;
  logic jump;
  logic [1:0] check_status;
  logic equal_cycles;
  logic signed [W:0] n_full;
  logic signed [W:0] d_full;
  logic [W:0] shifted;
  logic [W:0] init_diff;
  logic [W:0] step_diff;
  logic signed [tali_pkg::PROD_W-1:0] prod_adj;

  assign cw = tali_pkg::program_rom(pc);
  assign s_tready = (cw.op == tali_pkg::OP_TAKE);
  assign in_req = s_tvalid && s_tready;
  assign out_busy = m_tvalid && !m_tready;

  always_comb begin
    if (!b_present) begin
      check_status = tali_pkg::ST_NO_B;
    end else if (a_fill < 2'd2) begin
      check_status = tali_pkg::ST_A_SHORT;
    end else if (b_last_cycle < a_older_cycle || b_last_cycle > a_newer_cycle) begin
      check_status = tali_pkg::ST_RANGE;
    end else begin
      check_status = tali_pkg::ST_ALIGNED;
    end
  end

  assign equal_cycles = (a_older_cycle == a_newer_cycle);
  assign n_full = {b_last_cycle[W-1], b_last_cycle} - {a_older_cycle[W-1], a_older_cycle};
  assign d_full = {a_newer_cycle[W-1], a_newer_cycle} - {a_older_cycle[W-1], a_older_cycle};
  assign init_diff = {1'b0, n_full[W-1:0]} - {1'b0, d_full[W-1:0]};
  assign shifted = {rem, 1'b0};
  assign step_diff = shifted - {1'b0, divisor};
  assign prod_adj = prod + (prod[tali_pkg::PROD_W-1] ?
                    tali_pkg::PROD_W'((1 << tali_pkg::Q_FRAC) - 1) :
                    tali_pkg::PROD_W'(0));

  always_comb begin
    unique case (cw.cond)
      tali_pkg::COND_NEXT: jump = 1'b0;
      tali_pkg::COND_NO_REQ: jump = !in_req;
      tali_pkg::COND_SKIP: jump = (check_status != tali_pkg::ST_ALIGNED) || equal_cycles;
      tali_pkg::COND_CNT_LEFT: jump = (cnt != '0);
      tali_pkg::COND_OUT_BUSY: jump = out_busy;
      tali_pkg::COND_ALWAYS: jump = 1'b1;
      default: jump = 1'b1;
    endcase
    if (jump) begin
      pc_next = cw.target;
    end else if (cw.op == tali_pkg::OP_EMIT) begin
      pc_next = tali_pkg::STEP_TAKE;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= tali_pkg::STEP_TAKE;
      m_tvalid <= 1'b0;
      a_older_value <= '0;
      a_older_cycle <= '0;
      a_newer_value <= '0;
      a_newer_cycle <= '0;
      a_fill <= '0;
      b_last_value <= '0;
      b_last_cycle <= '0;
      b_present <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cw.op == tali_pkg::OP_EMIT && !out_busy) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (in_req) begin
        if (s_tuser[0] == 1'b0) begin
          a_older_value <= a_newer_value;
          a_older_cycle <= a_newer_cycle;
          a_newer_value <= s_tdata[31:0];
          a_newer_cycle <= s_tdata[63:32];
          if (a_fill < 2'd2) begin
            a_fill <= a_fill + 2'd1;
          end
        end else begin
          b_last_value <= s_tdata[31:0];
          b_last_cycle <= s_tdata[63:32];
          b_present <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cw.op)
      tali_pkg::OP_CHECK: begin
        res_status <= check_status;
        res_a <= '0;
        res_b <= '0;
        if (check_status == tali_pkg::ST_ALIGNED) begin
          res_b <= b_last_value;
          if (equal_cycles) begin
            res_a <= a_older_value;
          end
        end
      end
      tali_pkg::OP_DIV_INIT: begin
        divisor <= d_full[W-1:0];
        dv <= {a_newer_value[W-1], a_newer_value} - {a_older_value[W-1], a_older_value};
        cnt <= '1;
        if (!init_diff[W]) begin
          rem <= init_diff[W-1:0];
          quot <= tali_pkg::RATIO_W'(1);
        end else begin
          rem <= n_full[W-1:0];
          quot <= '0;
        end
      end
      tali_pkg::OP_DIV_STEP: begin
        cnt <= cnt - 1'b1;
        if (!step_diff[W]) begin
          rem <= step_diff[W-1:0];
          quot <= {quot[tali_pkg::RATIO_W-2:0], 1'b1};
        end else begin
          rem <= shifted[W-1:0];
          quot <= {quot[tali_pkg::RATIO_W-2:0], 1'b0};
        end
      end
      tali_pkg::OP_MUL: begin
        prod <= dv * $signed({1'b0, quot});
      end
      tali_pkg::OP_ADD: begin
        res_a <= a_older_value + prod_adj[tali_pkg::Q_FRAC +: W];
      end
      tali_pkg::OP_EMIT: begin
        if (!out_busy) begin
          m_tuser <= res_status;
          m_tdata <= {res_b, res_a};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== src/tali_checker.sv =====
// Port-level checker for the interpolation block, bound to the top level.
// Depends on the assertion macros header and tali_pkg.
`include "timestamp_aligned_linear_interp_top_defines.svh"

module tali_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic [1:0]  m_tuser
);

  logic s_seen;
  assign s_seen = s_tvalid && s_tready;

  `TALI_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `TALI_ASSERT_SAME(a_fail_zero, m_tvalid && m_tuser != tali_pkg::ST_ALIGNED, m_tdata == 64'd0, "failed status with data")
  `TALI_ASSERT_NEXT_ALWAYS(a_reset_idle, rst, !m_tvalid, "result valid after reset")
  `TALI_ASSERT_NEXT(a_one_in_flight, s_seen, !s_tready, "second request taken during work")

endmodule

bind timestamp_aligned_linear_interp_top tali_checker u_tali_checker (.*);

// ===== tb/tb_timestamp_aligned_linear_interp_top.sv =====
`timescale 1ns / 100ps
// Testbench for the timestamp aligned linear interpolation block.
// Sends A and B samples, predicts each status and interpolated value, and
// compares every master request; depends on tali_pkg and the top level only.
module tb_timestamp_aligned_linear_interp_top;

  localparam bit CH_A = 1'b0;
  localparam bit CH_B = 1'b1;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTS = 40;

  typedef struct {
    logic [1:0] status;
    logic [31:0] a_interp;
    logic [31:0] b_val;
  } align_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [1:0] m_tuser;

  int a_prev_val, a_prev_cyc, a_last_val, a_last_cyc;
  int a_count;
  int b_last_val, b_last_cyc;
  bit b_seen;

  align_result_t expected_q[$];
  align_result_t oldest;
  int error_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_arm = 0;
  int hold_seen = 0;
  int hold_left = 0;

  timestamp_aligned_linear_interp_top u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  always #2 clk = ~clk;

  initial begin
    #2_000_000;
    $display("[timestamp_aligned_linear_interp_top] ERROR");
    $finish;
  end

  function automatic int interp_at_b();
    longint n, d, r, dv, delta, q_one;
    q_one = longint'(1) << tali_pkg::Q_FRAC;
    if (a_prev_cyc == a_last_cyc) begin
      return a_prev_val;
    end
    n = longint'(b_last_cyc) - longint'(a_prev_cyc);
    d = longint'(a_last_cyc) - longint'(a_prev_cyc);
    r = (n * q_one) / d;
    dv = longint'(a_last_val) - longint'(a_prev_val);
    delta = (dv * r) / q_one;
    return int'(longint'(a_prev_val) + delta);
  endfunction

  function automatic align_result_t predict_alignment(bit ch, int val, int cyc);
    align_result_t res;
    res.status = tali_pkg::ST_ALIGNED;
    res.a_interp = '0;
    res.b_val = '0;
    if (ch == CH_A) begin
      a_prev_val = a_last_val;
      a_prev_cyc = a_last_cyc;
      a_last_val = val;
      a_last_cyc = cyc;
      if (a_count < 2) begin
        a_count++;
      end
    end else begin
      b_last_val = val;
      b_last_cyc = cyc;
      b_seen = 1'b1;
    end
    if (!b_seen) begin
      res.status = tali_pkg::ST_NO_B;
    end else if (a_count < 2) begin
      res.status = tali_pkg::ST_A_SHORT;
    end else if (b_last_cyc < a_prev_cyc || b_last_cyc > a_last_cyc) begin
      res.status = tali_pkg::ST_RANGE;
    end else begin
      res.a_interp = interp_at_b();
      res.b_val = b_last_val;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_PRINTS) begin
      $display("%0t mismatch in %s: got %h, expected %h", $realtime, what, got, want);
    end
  endtask

  always @(posedge clk) begin
    if (hold_left != 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_arm != hold_seen) begin
      hold_seen <= hold_arm;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, status", {30'd0, m_tuser}, 32'd0);
      end else begin
        oldest = expected_q.pop_front();
        if (m_tuser !== oldest.status) begin
          report_mismatch("status", {30'd0, m_tuser}, {30'd0, oldest.status});
        end
        if (m_tdata[31:0] !== oldest.a_interp) begin
          report_mismatch("a_interpolated", m_tdata[31:0], oldest.a_interp);
        end
        if (m_tdata[63:32] !== oldest.b_val) begin
          report_mismatch("b_value", m_tdata[63:32], oldest.b_val);
        end
      end
    end
  end

  task automatic send_sample(bit ch, int val, int cyc);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= ch;
    s_tdata <= {cyc, val};
    do @(posedge clk); while (!s_tready);
    expected_q.push_back(predict_alignment(ch, val, cyc));
  endtask

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct <= recv_pct;
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_startup_status();
    send_sample(CH_A, 32'h0001_0000, 100);
    send_sample(CH_B, 5, 150);
    send_sample(CH_A, 32'h0003_0000, 200);
  endtask

  task automatic test_range_bounds();
    send_sample(CH_B, 32'h0000_8000, 100);
    send_sample(CH_B, -32'sh0000_8000, 200);
    send_sample(CH_B, 11, 99);
    send_sample(CH_B, 12, 201);
    send_sample(CH_B, 13, 101);
  endtask

  task automatic test_equal_a_cycles();
    send_sample(CH_A, 7, 200);
    send_sample(CH_B, 21, 200);
    send_sample(CH_B, 22, 199);
  endtask

  task automatic test_a_out_of_order();
    send_sample(CH_A, 32'h0005_0000, 50);
    send_sample(CH_B, 31, 100);
    send_sample(CH_B, 32, 50);
  endtask

  task automatic test_value_extremes();
    send_sample(CH_A, 32'h8000_0000, 32'h8000_0000);
    send_sample(CH_A, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(CH_B, 32'h8000_0000, 0);
    send_sample(CH_B, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_sample(CH_B, -1, 32'h8000_0000);
    send_sample(CH_A, 32'h8000_0000, 32'h7FFF_FFFF);
    send_sample(CH_B, 32'h1234_5678, 12345);
    send_sample(CH_B, 0, 32'h7FFF_FFFE);
  endtask

  task automatic send_random_sample();
    int pick;
    bit ch;
    int val;
    int cyc;
    int stride;
    longint span, off;
    pick = $urandom_range(99);
    if ($urandom_range(3) == 0) begin
      val = $urandom;
    end else begin
      val = $urandom_range(32'h00FF_FFFF, 0) - 32'h0080_0000;
    end
    if (pick < 75) begin
      if ($urandom_range(9) < 3) begin
        ch = CH_A;
        if ($urandom_range(19) == 0) begin
          stride = $urandom_range(32'h7FFF_FFFF, 1);
        end else begin
          stride = $urandom_range(2000, 1);
        end
        cyc = a_last_cyc + stride;
      end else begin
        ch = CH_B;
        if (a_last_cyc >= a_prev_cyc) begin
          span = longint'(a_last_cyc) - longint'(a_prev_cyc);
          off = longint'({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_FFFF) % (span + 1);
          if ($urandom_range(7) == 0) begin
            off = $urandom_range(1) ? 0 : span;
          end
          cyc = int'(longint'(a_prev_cyc) + off);
        end else begin
          cyc = $urandom;
        end
      end
    end else if (pick < 90) begin
      ch = 1'($urandom_range(1));
      cyc = $urandom;
    end else begin
      ch = 1'($urandom_range(1));
      if (ch == CH_A) begin
        cyc = a_last_cyc;
      end else begin
        cyc = $urandom_range(1) ? a_prev_cyc - 1 : a_last_cyc + 1;
      end
    end
    send_sample(ch, val, cyc);
  endtask

  task automatic test_random_traffic(int count, int send_pct, int recv_pct);
    set_idling(send_pct, recv_pct);
    repeat (count) begin
      send_random_sample();
    end
    wait_drain();
  endtask

  task automatic test_receiver_hold_off();
    set_idling(0, 0);
    hold_arm <= hold_arm + 1;
    repeat (40) begin
      send_random_sample();
    end
    wait_drain();
  endtask

  initial begin
    a_prev_val = 0;
    a_prev_cyc = 0;
    a_last_val = 0;
    a_last_cyc = 0;
    a_count = 0;
    b_last_val = 0;
    b_last_cyc = 0;
    b_seen = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_idling(0, 0);
    test_startup_status();
    test_range_bounds();
    test_equal_a_cycles();
    test_a_out_of_order();
    test_value_extremes();
    wait_drain();

    test_random_traffic(340, 0, 0);
    test_random_traffic(340, 67, 0);
    test_random_traffic(340, 0, 67);
    test_random_traffic(340, 6, 6);
    test_receiver_hold_off();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("[timestamp_aligned_linear_interp_top] OK");
    end else begin
      $display("[timestamp_aligned_linear_interp_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+src
src/tali_pkg.sv
src/timestamp_aligned_linear_interp_top.sv
src/tali_checker.sv
tb/tb_timestamp_aligned_linear_interp_top.sv
